### hdl/cpr_pkg.sv
// Shared constants and cell control/status types for the clock page replacement block.
`timescale 1ns / 1ps

package cpr_pkg;

  localparam int MAX_FRAMES = 16;
  localparam int PAGE_BITS  = 20;
  localparam int FRAME_W    = $clog2(MAX_FRAMES);
  localparam int CNT_W      = $clog2(MAX_FRAMES + 1);

  // Control broadcast from the sequencer to every frame cell.
  typedef struct packed {
    logic clear;    // empty the frame and bring the token home
    logic adv;      // the token steps to the next cell this cycle
    logic hit_set;  // set the reference bit of the first matching cell
  } cell_ctrl_t;

  // What each frame cell reports back to the top level.
  typedef struct packed {
    logic                 tok;
    logic                 ref_bit;
    logic                 valid;
    logic                 first_hit;
    logic [PAGE_BITS-1:0] page;
  } cell_stat_t;

endpackage

### hdl/cpr_if.sv
// Handshake channels for page references and replacement results.
`timescale 1ns / 1ps

interface cpr_page_if;
  logic                          valid;
  logic                          ready;
  logic [cpr_pkg::PAGE_BITS-1:0] page_number;

  modport source (output valid, output page_number, input ready);
  modport sink   (input valid, input page_number, output ready);
endinterface

interface cpr_result_if;
  logic                          valid;
  logic                          ready;
  logic                          page_fault;
  logic [cpr_pkg::FRAME_W-1:0]   frame_index;
  logic                          evicted_valid;
  logic [cpr_pkg::PAGE_BITS-1:0] evicted_page;

  modport source (output valid, output page_fault, output frame_index,
                  output evicted_valid, output evicted_page, input ready);
  modport sink   (input valid, input page_fault, input frame_index,
                  input evicted_valid, input evicted_page, output ready);
endinterface

### hdl/clock_page_replacement.sv
// Top level of the second-chance clock page replacement block.
//
//  Port         Dir  Flow control    Carries
//  page_i       in   valid/ready     page_number
//  result_o     out  valid/ready     page_fault, frame_index, evicted_valid, evicted_page
//  cfg_we_i     in   write enable    cfg_wdata_i = frames_in_use
//
// A hit is resolved in the lookup state. A miss goes on to a sweep in which the hand
// token passes k set reference bits (k from 0 to frames_in_use), moving one cell per cycle
// along the row of frame cells, and stops at the first cell whose bit is clear. After the
// result is loaded the sequencer returns to idle and takes the next item from there.
// One item is in work at a time; a new item is accepted while the result waits.
// A stalled result holds the sequencer before the hit update or the placement.
// Reset and a frame count write empty all frames and return the hand to frame zero.
`timescale 1ns / 1ps

module clock_page_replacement (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [cpr_pkg::CNT_W-1:0] cfg_wdata_i,
  cpr_page_if.sink                  page_i,
  cpr_result_if.source              result_o
);
  import cpr_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_SWEEP
  } state_e;

  state_e               state_q;
  logic [CNT_W-1:0]     n_q;
  logic [CNT_W-1:0]     n_d;
  logic [PAGE_BITS-1:0] page_q;

  logic                 out_valid_q;
  logic                 out_fault_q;
  logic [FRAME_W-1:0]   out_frame_q;
  logic                 out_ev_valid_q;
  logic [PAGE_BITS-1:0] out_ev_page_q;

  cell_ctrl_t           ctrl;
  cell_stat_t           stat [MAX_FRAMES];
  logic [MAX_FRAMES:0]  found;
  logic [MAX_FRAMES-1:0] tok_in;
  logic [MAX_FRAMES-1:0] last;

  logic                 out_free;
  logic                 out_load;
  logic                 any_hit;
  logic                 stop;
  logic [FRAME_W-1:0]   hit_idx;
  logic [FRAME_W-1:0]   hand_idx;
  logic                 ev_valid;
  logic [PAGE_BITS-1:0] ev_page;
  logic                 tok_wrap;

  assign page_i.ready = (state_q == S_IDLE);
  assign out_free     = !out_valid_q || result_o.ready;
  assign any_hit      = found[MAX_FRAMES];
  assign found[0]     = 1'b0;
  assign out_load     = out_free && (((state_q == S_LOOKUP) && any_hit) ||
                                     ((state_q == S_SWEEP) && stop));

  genvar gi;
  generate
    for (gi = 0; gi < MAX_FRAMES; gi++) begin : g_cell
      assign last[gi] = (CNT_W'(gi) == (n_q - CNT_W'(1)));
      if (gi == 0) begin : g_first
        assign tok_in[gi] = tok_wrap;
      end else begin : g_rest
        assign tok_in[gi] = stat[gi-1].tok && !last[gi-1];
      end
      cpr_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctrl_i  (ctrl),
        .page_i  (page_q),
        .home_i  ((gi == 0) ? 1'b1 : 1'b0),
        .tok_i   (tok_in[gi]),
        .found_i (found[gi]),
        .found_o (found[gi+1]),
        .stat_o  (stat[gi])
      );
    end
  endgenerate

  // Gather the token cell's contents and the first hit across the row.
  always_comb begin
    tok_wrap = 1'b0;
    stop     = 1'b0;
    hit_idx  = '0;
    hand_idx = '0;
    ev_valid = 1'b0;
    ev_page  = '0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      tok_wrap = tok_wrap | (stat[i].tok & last[i]);
      stop     = stop | (stat[i].tok & !stat[i].ref_bit);
      if (stat[i].first_hit) begin
        hit_idx = hit_idx | FRAME_W'(i);
      end
      if (stat[i].tok) begin
        hand_idx = hand_idx | FRAME_W'(i);
        ev_valid = ev_valid | stat[i].valid;
      end
      if (stat[i].tok && stat[i].valid) begin
        ev_page = ev_page | stat[i].page;
      end
    end
  end

  always_comb begin
    ctrl.clear   = cfg_we_i;
    ctrl.hit_set = (state_q == S_LOOKUP) && any_hit && out_free;
    ctrl.adv     = (state_q == S_SWEEP) && (!stop || out_free);
  end

  // A count of zero is taken as one frame, and anything above the table size as the full table.
  always_comb begin
    n_d = cfg_wdata_i;
    if (cfg_wdata_i == '0) begin
      n_d = CNT_W'(1);
    end else if (cfg_wdata_i > CNT_W'(MAX_FRAMES)) begin
      n_d = CNT_W'(MAX_FRAMES);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= CNT_W'(MAX_FRAMES);
    end else if (cfg_we_i) begin
      n_q <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (page_i.valid && page_i.ready) begin
      page_q <= page_i.page_number;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      out_valid_q    <= 1'b0;
      out_fault_q    <= 1'b0;
      out_frame_q    <= '0;
      out_ev_valid_q <= 1'b0;
      out_ev_page_q  <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (page_i.valid) begin
            state_q <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          if (!any_hit) begin
            state_q <= S_SWEEP;
          end else if (out_free) begin
            out_fault_q    <= 1'b0;
            out_frame_q    <= hit_idx;
            out_ev_valid_q <= 1'b0;
            out_ev_page_q  <= '0;
            state_q        <= S_IDLE;
          end
        end
        S_SWEEP: begin
          if (stop && out_free) begin
            out_fault_q    <= 1'b1;
            out_frame_q    <= hand_idx;
            out_ev_valid_q <= ev_valid;
            out_ev_page_q  <= ev_page;
            state_q        <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.page_fault    = out_fault_q;
  assign result_o.frame_index   = out_frame_q;
  assign result_o.evicted_valid = out_ev_valid_q;
  assign result_o.evicted_page  = out_ev_page_q;

`ifndef SYNTH
  logic [MAX_FRAMES-1:0] tok_vec;
  always_comb begin
    for (int i = 0; i < MAX_FRAMES; i++) begin
      tok_vec[i] = stat[i].tok;
    end
  end

  a_one_hand : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(tok_vec))
    else $error("clock hand token is not one-hot");

  a_hand_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWEEP) |-> ({1'b0, hand_idx} < n_q))
    else $error("clock hand beyond frames in use");

  a_hit_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_LOOKUP) && any_hit) |-> ({1'b0, hit_idx} < n_q))
    else $error("hit found in a frame beyond frames in use");

  a_hit_no_evict : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_fault_q) |-> !out_ev_valid_q)
    else $error("hit result reports an eviction");
`endif

endmodule

### hdl/cpr_cell.sv
// One frame of the clock: stored page, valid and reference bits, and the hand token.
`timescale 1ns / 1ps

module cpr_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cpr_pkg::cell_ctrl_t           ctrl_i,
  input  logic [cpr_pkg::PAGE_BITS-1:0] page_i,
  input  logic                          home_i,
  input  logic                          tok_i,
  input  logic                          found_i,
  output logic                          found_o,
  output cpr_pkg::cell_stat_t           stat_o
);
  import cpr_pkg::*;

  logic                 valid_q;
  logic                 ref_q;
  logic                 tok_q;
  logic [PAGE_BITS-1:0] page_q;
  logic                 tok;
  logic                 match;
  logic                 place;

  // The token is stored relative to the home cell, so reset puts it at frame zero.
  assign tok     = tok_q ^ home_i;
  assign match   = valid_q && (page_q == page_i);
  assign found_o = found_i | match;
  assign place   = ctrl_i.adv && tok && !ref_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      ref_q   <= 1'b0;
      tok_q   <= 1'b0;
    end else if (ctrl_i.clear) begin
      valid_q <= 1'b0;
      ref_q   <= 1'b0;
      tok_q   <= 1'b0;
    end else begin
      if (ctrl_i.adv) begin
        tok_q <= tok_i ^ home_i;
      end
      if (ctrl_i.adv && tok) begin
        if (ref_q) begin
          ref_q <= 1'b0;
        end else begin
          valid_q <= 1'b1;
          ref_q   <= 1'b1;
        end
      end else if (ctrl_i.hit_set && match && !found_i) begin
        ref_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!ctrl_i.clear && place) begin
      page_q <= page_i;
    end
  end

  assign stat_o.tok       = tok;
  assign stat_o.ref_bit   = ref_q;
  assign stat_o.valid     = valid_q;
  assign stat_o.first_hit = match && !found_i;
  assign stat_o.page      = page_q;

endmodule
